### rtl/potb_pkg.sv
package potb_pkg;

   // bank size and time format
   localparam int SLOTS     = 32;
   localparam int TIME_BITS = 32;
   localparam int HIDX_W    = $clog2(SLOTS);
   localparam int COUNT_W   = $clog2(SLOTS + 1);
   localparam int WIDE_W    = (TIME_BITS > 32) ? TIME_BITS : 32;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [HIDX_W-1:0]    slot_idx_type;
   typedef logic [COUNT_W-1:0]   count_type;

   localparam time_type  TIME_MAX    = '1;
   localparam count_type COUNT_ONE   = count_type'(1);
   localparam count_type COUNT_ZERO  = '0;
   localparam count_type COUNT_SLOTS = count_type'(SLOTS);

   // request op codes
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_PERIODIC = 2'd1,
      OP_ONE_SHOT = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_GRANTED = 2'd0,
      KIND_FULL    = 2'd1,
      KIND_FIRED   = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   // command to the slot store
   typedef struct packed {
      logic         rd;
      logic         wr_all;
      logic         wr_elapsed;
      slot_idx_type addr;
      time_type     interval;
      time_type     elapsed;
      logic         one_shot;
   } slot_cmd_type;

   // registered read data of one slot
   typedef struct packed {
      time_type interval;
      time_type elapsed;
      logic     one_shot;
   } slot_data_type;

   // clamp a 32-bit time field to the time format
   function automatic time_type clamp_time(input logic [31:0] v);
      logic [WIDE_W-1:0] w;
      logic [WIDE_W-1:0] m;
      w = WIDE_W'(v);
      m = WIDE_W'(TIME_MAX);
      if (w > m) begin
         w = m;
      end
      return w[TIME_BITS-1:0];
   endfunction

   // slot index onto the 5-bit handle field
   function automatic logic [4:0] out_handle(input slot_idx_type h);
      logic [HIDX_W+4:0] w;
      w = {5'b0, h};
      return w[4:0];
   endfunction

endpackage

### rtl/potb_if.sv
// request channel: op and time fields
interface potb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [31:0] interval;
   logic [31:0] delta;

   modport source (output valid, output op, output interval, output delta, input ready);
   modport sink (input valid, input op, input interval, input delta, output ready);
endinterface

// result channel: kind, handle, last
interface potb_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [4:0] handle;
   logic       last;

   modport source (output valid, output kind, output handle, output last, input ready);
   modport sink (input valid, input kind, input handle, input last, output ready);
endinterface

### rtl/potb_time_alu.sv
// Shared time unit: compares elapsed against interval and forms the
// saturating sum elapsed + delta. Used once per visited slot.
module potb_time_alu (
   input  potb_pkg::time_type elapsed,
   input  potb_pkg::time_type interval,
   input  potb_pkg::time_type delta,
   output logic               below,
   output potb_pkg::time_type sum
);

   logic [potb_pkg::TIME_BITS:0] raw;

   // compare and add
   always_comb begin
      below = (elapsed < interval);
      raw   = {1'b0, elapsed} + {1'b0, delta};
      if (raw[potb_pkg::TIME_BITS]) begin
         sum = potb_pkg::TIME_MAX;
      end else begin
         sum = raw[potb_pkg::TIME_BITS-1:0];
      end
   end

endmodule

### rtl/potb_slot_store.sv
// Per-slot interval, elapsed time and one-shot flag; one access a cycle,
// read data registered.
module potb_slot_store (
   input  logic                    clock,
   input  potb_pkg::slot_cmd_type  cmd,
   output potb_pkg::slot_data_type rdata
);

   potb_pkg::time_type int_mem [potb_pkg::SLOTS];
   potb_pkg::time_type el_mem  [potb_pkg::SLOTS];
   logic               os_mem  [potb_pkg::SLOTS];
   potb_pkg::slot_data_type rdata_ff;

   // writes
   always_ff @(posedge clock) begin
      if (cmd.wr_all) begin
         int_mem[cmd.addr] <= cmd.interval;
         os_mem[cmd.addr]  <= cmd.one_shot;
      end
      if (cmd.wr_all || cmd.wr_elapsed) begin
         el_mem[cmd.addr] <= cmd.elapsed;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff.interval <= int_mem[cmd.addr];
         rdata_ff.elapsed  <= el_mem[cmd.addr];
         rdata_ff.one_shot <= os_mem[cmd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/periodic_oneshot_timer_bank.sv
// Schedule: a fresh handle goes from the accept to the grant state, a recycled one first
// passes the pop state; the grant state registers the result once the result register is free.
// Tick: read-run, read-slot and evaluate states per running timer, plus a move state per
// fired one-shot, then the done beat; one sequencer over one shared time unit.
// The request side is not ready until the last result of a beat is registered.
// Synchronous active-high reset clears the counts, sequencer and result valid;
// the slot, run-list and freed-stack memories are not cleared.
module periodic_oneshot_timer_bank (
   input  logic            clock,
   input  logic            reset,
   potb_req_if.sink        req_ch,
   potb_rsp_if.source      rsp_ch
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_POP     = 9'b000000010,
      S_GRANT   = 9'b000000100,
      S_FULL    = 9'b000001000,
      S_RD_RUN  = 9'b000010000,
      S_RD_SLOT = 9'b000100000,
      S_EVAL    = 9'b001000000,
      S_MOVE    = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   potb_pkg::count_type    run_count_ff, run_count_in;
   potb_pkg::count_type    freed_count_ff, freed_count_in;
   potb_pkg::count_type    fresh_count_ff, fresh_count_in;
   potb_pkg::count_type    idx_ff, idx_in;
   potb_pkg::slot_idx_type hdl_ff, hdl_in;
   potb_pkg::time_type     interval_ff, interval_in;
   potb_pkg::time_type     delta_ff, delta_in;
   logic                   one_shot_ff, one_shot_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   potb_pkg::kind_type     kind_ff, kind_in;
   logic [4:0]             handle_ff, handle_in;
   logic                   last_ff, last_in;

   potb_pkg::slot_idx_type run_mem [potb_pkg::SLOTS];
   potb_pkg::slot_idx_type run_rdata_ff;
   logic                   run_rd, run_wr;
   potb_pkg::slot_idx_type run_ra, run_wa, run_wd;

   potb_pkg::slot_idx_type freed_mem [potb_pkg::SLOTS];
   potb_pkg::slot_idx_type freed_rdata_ff;
   logic                   freed_rd, freed_wr;
   potb_pkg::slot_idx_type freed_ra, freed_wa, freed_wd;

   potb_pkg::slot_cmd_type  slot_cmd;
   potb_pkg::slot_data_type slot_data;
   logic                    alu_below;
   potb_pkg::time_type      alu_sum;

   logic                emit;
   potb_pkg::kind_type  emit_kind;
   logic [4:0]          emit_handle;
   logic                emit_last;
   logic                out_free;
   logic                req_fire;
   potb_pkg::count_type idx_dec, run_dec, freed_dec;
   potb_pkg::op_type    req_op;

   // slot memories and shared time unit
   potb_slot_store u_store (
      .clock (clock),
      .cmd   (slot_cmd),
      .rdata (slot_data)
   );

   potb_time_alu u_alu (
      .elapsed  (slot_data.elapsed),
      .interval (slot_data.interval),
      .delta    (delta_ff),
      .below    (alu_below),
      .sum      (alu_sum)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_op       = potb_pkg::op_type'(req_ch.op);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign idx_dec      = idx_ff - potb_pkg::COUNT_ONE;
   assign run_dec      = run_count_ff - potb_pkg::COUNT_ONE;
   assign freed_dec    = freed_count_ff - potb_pkg::COUNT_ONE;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      run_count_in   = run_count_ff;
      freed_count_in = freed_count_ff;
      fresh_count_in = fresh_count_ff;
      idx_in         = idx_ff;
      hdl_in         = hdl_ff;
      interval_in    = interval_ff;
      delta_in       = delta_ff;
      one_shot_in    = one_shot_ff;

      run_rd   = 1'b0;
      run_wr   = 1'b0;
      run_ra   = idx_dec[potb_pkg::HIDX_W-1:0];
      run_wa   = idx_ff[potb_pkg::HIDX_W-1:0];
      run_wd   = run_rdata_ff;
      freed_rd = 1'b0;
      freed_wr = 1'b0;
      freed_ra = freed_dec[potb_pkg::HIDX_W-1:0];
      freed_wa = freed_count_ff[potb_pkg::HIDX_W-1:0];
      freed_wd = hdl_ff;

      slot_cmd            = '0;
      slot_cmd.addr       = hdl_ff;
      slot_cmd.interval   = interval_ff;
      slot_cmd.one_shot   = one_shot_ff;
      slot_cmd.elapsed    = alu_sum;

      emit        = 1'b0;
      emit_kind   = potb_pkg::KIND_DONE;
      emit_handle = 5'd0;
      emit_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               interval_in = potb_pkg::clamp_time(req_ch.interval);
               delta_in    = potb_pkg::clamp_time(req_ch.delta);
               one_shot_in = (req_op == potb_pkg::OP_ONE_SHOT);
               case (req_op)
                  potb_pkg::OP_PERIODIC, potb_pkg::OP_ONE_SHOT: begin
                     if (freed_count_ff != potb_pkg::COUNT_ZERO) begin
                        freed_rd       = 1'b1;
                        freed_count_in = freed_dec;
                        state_in       = S_POP;
                     end else if (fresh_count_ff < potb_pkg::COUNT_SLOTS) begin
                        hdl_in         = fresh_count_ff[potb_pkg::HIDX_W-1:0];
                        fresh_count_in = fresh_count_ff + potb_pkg::COUNT_ONE;
                        state_in       = S_GRANT;
                     end else begin
                        state_in = S_FULL;
                     end
                  end
                  potb_pkg::OP_TICK: begin
                     idx_in = run_count_ff;
                     if (run_count_ff == potb_pkg::COUNT_ZERO) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_RD_RUN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_POP: begin
            hdl_in   = freed_rdata_ff;
            state_in = S_GRANT;
         end
         S_GRANT: begin
            if (out_free) begin
               slot_cmd.wr_all  = 1'b1;
               slot_cmd.elapsed = '0;
               run_wr       = 1'b1;
               run_wa       = run_count_ff[potb_pkg::HIDX_W-1:0];
               run_wd       = hdl_ff;
               run_count_in = run_count_ff + potb_pkg::COUNT_ONE;
               emit         = 1'b1;
               emit_kind    = potb_pkg::KIND_GRANTED;
               emit_handle  = potb_pkg::out_handle(hdl_ff);
               state_in     = S_IDLE;
            end
         end
         S_FULL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = potb_pkg::KIND_FULL;
               state_in  = S_IDLE;
            end
         end
         S_RD_RUN: begin
            run_rd   = 1'b1;
            idx_in   = idx_dec;
            state_in = S_RD_SLOT;
         end
         S_RD_SLOT: begin
            hdl_in        = run_rdata_ff;
            slot_cmd.rd   = 1'b1;
            slot_cmd.addr = run_rdata_ff;
            state_in      = S_EVAL;
         end
         S_EVAL: begin
            if (alu_below) begin
               // still counting: accumulate delta
               slot_cmd.wr_elapsed = 1'b1;
               state_in = (idx_ff == potb_pkg::COUNT_ZERO) ? S_DONE : S_RD_RUN;
            end else if (out_free) begin
               emit        = 1'b1;
               emit_kind   = potb_pkg::KIND_FIRED;
               emit_handle = potb_pkg::out_handle(hdl_ff);
               emit_last   = 1'b0;
               if (slot_data.one_shot) begin
                  // drop from run list, fetch last entry to fill the hole
                  run_count_in   = run_dec;
                  run_rd         = 1'b1;
                  run_ra         = run_dec[potb_pkg::HIDX_W-1:0];
                  freed_wr       = 1'b1;
                  freed_count_in = freed_count_ff + potb_pkg::COUNT_ONE;
                  state_in       = S_MOVE;
               end else begin
                  slot_cmd.wr_elapsed = 1'b1;
                  slot_cmd.elapsed    = '0;
                  state_in = (idx_ff == potb_pkg::COUNT_ZERO) ? S_DONE : S_RD_RUN;
               end
            end
         end
         S_MOVE: begin
            run_wr   = 1'b1;
            state_in = (idx_ff == potb_pkg::COUNT_ZERO) ? S_DONE : S_RD_RUN;
         end
         S_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      kind_in      = kind_ff;
      handle_in    = handle_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = emit_kind;
         handle_in    = emit_handle;
         last_in      = emit_last;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.kind   = kind_ff;
   assign rsp_ch.handle = handle_ff;
   assign rsp_ch.last   = last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         run_count_ff   <= '0;
         freed_count_ff <= '0;
         fresh_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         run_count_ff   <= run_count_in;
         freed_count_ff <= freed_count_in;
         fresh_count_ff <= fresh_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hdl_ff      <= hdl_in;
      interval_ff <= interval_in;
      delta_ff    <= delta_in;
      one_shot_ff <= one_shot_in;
      kind_ff     <= kind_in;
      handle_ff   <= handle_in;
      last_ff     <= last_in;
   end

   // run list memory
   always_ff @(posedge clock) begin
      if (run_wr) begin
         run_mem[run_wa] <= run_wd;
      end
      if (run_rd) begin
         run_rdata_ff <= run_mem[run_ra];
      end
   end

   // freed handle stack memory
   always_ff @(posedge clock) begin
      if (freed_wr) begin
         freed_mem[freed_wa] <= freed_wd;
      end
      if (freed_rd) begin
         freed_rdata_ff <= freed_mem[freed_ra];
      end
   end

endmodule

### rtl/potb_checker.sv
// Port-level checks for the timer bank.
module potb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_op,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [4:0] rsp_handle,
   input logic       rsp_last
);

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_handle)
         && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // only a fired beat is not the last of its request
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != potb_pkg::KIND_FIRED)))
      else $error("last flag does not match result kind");

   // pool-full and tick-done carry no handle
   a_zero_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == potb_pkg::KIND_FULL || rsp_kind == potb_pkg::KIND_DONE)
         |-> rsp_handle == 5'd0)
      else $error("nonzero handle on full or done");

   // a working request blocks the next one
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op != potb_pkg::OP_UNUSED |=> !req_ready)
      else $error("request side ready while busy");

endmodule

bind periodic_oneshot_timer_bank potb_checker u_potb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_op     (req_ch.op),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.kind),
   .rsp_handle (rsp_ch.handle),
   .rsp_last   (rsp_ch.last)
);

### verif/potb_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the timer bank, predicts the result beats of each
// accepted request and compares them in order with the beats that come out.
module potb_tb_checker (
   input  logic clock,
   input  logic reset,
   potb_req_if  req_mon,
   potb_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct {
      potb_pkg::kind_type kind;
      logic [4:0]         handle;
      logic               last;
   } result_beat_type;

   // shadow copy of the bank
   potb_pkg::time_type tmr_interval [potb_pkg::SLOTS];
   potb_pkg::time_type tmr_elapsed  [potb_pkg::SLOTS];
   logic               tmr_one_shot [potb_pkg::SLOTS];
   int                 run_list     [potb_pkg::SLOTS];
   int                 free_stack   [potb_pkg::SLOTS];
   int                 run_len;
   int                 free_len;
   int                 fresh_next;

   result_beat_type due_beats[$];
   result_beat_type want;
   int              errs;

   initial begin
      errs = 0;
   end

   function automatic void queue_beat(input potb_pkg::kind_type k, input int h,
                                      input logic lst);
      result_beat_type b;
      b.kind   = k;
      b.handle = 5'(h);
      b.last   = lst;
      due_beats.push_back(b);
   endfunction

   // one request: update the shadow bank, queue the beats it causes
   task automatic advance_timers(input potb_pkg::op_type op, input logic [31:0] ival,
                                 input logic [31:0] dlt);
      potb_pkg::time_type           iv;
      potb_pkg::time_type           dv;
      logic [potb_pkg::TIME_BITS:0] sum;
      int                           h;
      int                           i;
      // narrow time formats clamp the 32-bit fields
      iv = (64'(ival) > 64'(potb_pkg::TIME_MAX)) ? potb_pkg::TIME_MAX
                                                 : potb_pkg::time_type'(ival);
      dv = (64'(dlt) > 64'(potb_pkg::TIME_MAX)) ? potb_pkg::TIME_MAX
                                                : potb_pkg::time_type'(dlt);
      case (op)
         potb_pkg::OP_PERIODIC, potb_pkg::OP_ONE_SHOT: begin
            h = -1;
            // LIFO reuse first, then a never-used handle
            if (free_len > 0) begin
               free_len--;
               h = free_stack[free_len];
            end else if (fresh_next < potb_pkg::SLOTS) begin
               h = fresh_next;
               fresh_next++;
            end
            if (h < 0) begin
               queue_beat(potb_pkg::KIND_FULL, 0, 1'b1);
            end else begin
               tmr_interval[h]   = iv;
               tmr_elapsed[h]    = '0;
               tmr_one_shot[h]   = (op == potb_pkg::OP_ONE_SHOT);
               run_list[run_len] = h;
               run_len++;
               queue_beat(potb_pkg::KIND_GRANTED, h, 1'b1);
            end
         end
         potb_pkg::OP_TICK: begin
            // walk the run list from the back; a moved entry is not revisited
            i = run_len;
            while (i > 0) begin
               i--;
               h = run_list[i];
               if (tmr_elapsed[h] < tmr_interval[h]) begin
                  sum = {1'b0, tmr_elapsed[h]} + {1'b0, dv};
                  tmr_elapsed[h] = sum[potb_pkg::TIME_BITS] ? potb_pkg::TIME_MAX
                                                            : sum[potb_pkg::TIME_BITS-1:0];
               end else begin
                  queue_beat(potb_pkg::KIND_FIRED, h, 1'b0);
                  if (tmr_one_shot[h]) begin
                     run_len--;
                     run_list[i] = run_list[run_len];
                     free_stack[free_len] = h;
                     free_len++;
                  end else begin
                     tmr_elapsed[h] = '0;
                  end
               end
            end
            queue_beat(potb_pkg::KIND_DONE, 0, 1'b1);
         end
         default: ; // unused op: no beat, no change
      endcase
   endtask

   // result beats first, then the request beat of the same edge
   always @(posedge clock) begin
      if (reset) begin
         run_len    = 0;
         free_len   = 0;
         fresh_next = 0;
         due_beats.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_beats.size() == 0) begin
               $error("result beat with nothing due: kind %0d handle %0d last %0d",
                      rsp_mon.kind, rsp_mon.handle, rsp_mon.last);
               errs++;
            end else begin
               want = due_beats.pop_front();
               if (rsp_mon.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_mon.kind);
                  errs++;
               end
               if (rsp_mon.handle !== want.handle) begin
                  $error("handle: expected %0d, got %0d", want.handle, rsp_mon.handle);
                  errs++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_mon.last);
                  errs++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_timers(potb_pkg::op_type'(req_mon.op), req_mon.interval,
                           req_mon.delta);
         end
      end
      fail_count <= errs;
      pending    <= due_beats.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

   logic clock;
   logic reset;
   logic steady   = 1'b0;
   logic squeeze  = 1'b0;
   logic squeezed = 1'b0;
   int   fail_count;
   int   pending;
   int   items_sent    = 0;
   int   periodic_left = 20;

   potb_req_if req_bus ();
   potb_rsp_if rsp_bus ();

   periodic_oneshot_timer_bank DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   potb_tb_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #18_000_000;
      $display("Some tests failed");
      $finish;
   end

   // present one request beat, with random idle cycles ahead of it
   task automatic send_req(input potb_pkg::op_type op, input logic [31:0] iv,
                           input logic [31:0] dt);
      potb_pkg::op_type sent_op;
      sent_op = op;
      // keep periodic timers rare so the pool does not stay full
      if (sent_op == potb_pkg::OP_PERIODIC) begin
         if (periodic_left == 0) begin
            sent_op = potb_pkg::OP_ONE_SHOT;
         end else begin
            periodic_left--;
         end
      end
      if (sent_op != potb_pkg::OP_UNUSED) begin
         items_sent++;
      end
      while (!steady && $urandom_range(0, 99) < 36) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= sent_op;
      req_bus.interval <= iv;
      req_bus.delta    <= dt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // mostly small times, with the extremes and full-range values mixed in
   function automatic logic [31:0] pick_time(input logic [31:0] spread);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom();
         default: return $urandom_range(0, spread);
      endcase
   endfunction

   // result side: random stalls, one long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeezed) begin
            squeezed = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 36);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int               seg;
      int               r;
      int               waited;
      bit               first;
      potb_pkg::op_type op;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.op       <= potb_pkg::OP_TICK;
      req_bus.interval <= '0;
      req_bus.delta    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tick, unused op, zero and all-ones times, reuse, moved entry
      send_req(potb_pkg::OP_TICK, '0, '0);
      send_req(potb_pkg::OP_UNUSED, '1, '1);
      send_req(potb_pkg::OP_PERIODIC, '0, '1);
      send_req(potb_pkg::OP_ONE_SHOT, '0, '0);
      send_req(potb_pkg::OP_TICK, '0, '0);
      send_req(potb_pkg::OP_ONE_SHOT, '1, '0);
      send_req(potb_pkg::OP_PERIODIC, 32'd1, '0);
      send_req(potb_pkg::OP_TICK, '1, '1);
      send_req(potb_pkg::OP_TICK, '0, '0);
      send_req(potb_pkg::OP_ONE_SHOT, 32'h0002_8000, '0);
      send_req(potb_pkg::OP_ONE_SHOT, 32'h0001_0000, '0);
      send_req(potb_pkg::OP_TICK, '0, 32'h0001_0000);
      send_req(potb_pkg::OP_TICK, '0, 32'h0001_8000);
      send_req(potb_pkg::OP_TICK, '0, 32'hFFFF_0000);
      send_req(potb_pkg::OP_UNUSED, '0, '0);

      // random segments; the first one fills the pool past its limit
      first = 1'b1;
      while (items_sent < 420) begin
         seg   = first ? 0 : $urandom_range(0, 3);
         first = 1'b0;
         case (seg)
            0: begin
               // burst of schedules, long intervals
               repeat (36) begin
                  op = ($urandom_range(0, 19) == 0) ? potb_pkg::OP_PERIODIC
                                                    : potb_pkg::OP_ONE_SHOT;
                  send_req(op, $urandom_range(32'h0001_0000, 32'h0040_0000), $urandom());
               end
            end
            1: begin
               // mix of ticks and schedules with short times
               repeat (20) begin
                  r = $urandom_range(0, 99);
                  if (r < 45) begin
                     send_req(potb_pkg::OP_TICK, $urandom(), pick_time(32'h0002_0000));
                  end else if (r < 95) begin
                     op = ($urandom_range(0, 7) == 0) ? potb_pkg::OP_PERIODIC
                                                      : potb_pkg::OP_ONE_SHOT;
                     send_req(op, pick_time(32'h0008_0000), $urandom());
                  end else begin
                     send_req(potb_pkg::OP_UNUSED, $urandom(), $urandom());
                  end
               end
            end
            2: begin
               // large ticks to saturate and fire
               repeat (6) begin
                  send_req(potb_pkg::OP_TICK, $urandom(),
                           ($urandom_range(0, 2) == 0) ? '1 : $urandom());
               end
            end
            default: begin
               // raw fields
               repeat (15) begin
                  send_req(potb_pkg::op_type'($urandom_range(0, 3)), $urandom(),
                           $urandom());
               end
            end
         endcase
         if (items_sent >= 150) begin
            squeeze <= 1'b1;
         end
         steady <= (items_sent >= 250 && items_sent < 330);
      end
      req_bus.valid <= 1'b0;
      steady        <= 1'b0;

      // drain
      repeat (2) @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (pending != 0) begin
         $error("%0d result beats never arrived", pending);
      end
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
